### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LCD nibble writer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/clnw_pkg.sv
// ---------------------------------------------------------------------------
// clnw_pkg
// Types and constants shared by the character LCD nibble writer.
// ---------------------------------------------------------------------------
package clnw_pkg;

    // Decimal conversion limits
    localparam int MAX_DIGITS = 5;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_ONE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TWO_BASE = 2'd1;

    // Register reset values
    localparam logic [7:0] LINE_ONE_RESET = 8'd128;
    localparam logic [7:0] LINE_TWO_RESET = 8'd192;

    // Cursor rows
    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;

    // Register select codes
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_CURSOR = 2'd2,
        KIND_NUMBER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [1:0]  row;
        logic [4:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [3:0] nibble;
        logic       reg_select;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [12:0] quotient;
        logic [3:0]  remainder;
    } t_div_result;

endpackage

### hw/rtl/clnw_div10.sv
// ---------------------------------------------------------------------------
// clnw_div10
// Divide a 16-bit value by ten: reciprocal multiply plus remainder fix-up.
// ---------------------------------------------------------------------------
module clnw_div10 (
    input  logic [15:0]               i_dividend,
    output clnw_pkg::t_div_result     o_result
);
    import clnw_pkg::*;

    // 2^19 / 10 rounded up; exact for every 16-bit dividend
    localparam logic [15:0] RECIP = 16'hCCCD;

    logic [31:0] w_product;
    logic [12:0] w_quot;
    logic [15:0] w_times_ten;
    logic [15:0] w_diff;

    // Take the quotient from the scaled product
    assign w_product   = {16'd0, i_dividend} * {16'd0, RECIP};
    assign w_quot      = w_product[31:19];

    // Rebuild quotient times ten with shifts and subtract
    assign w_times_ten = {w_quot[12:0], 3'b000} + {2'b00, w_quot[12:0], 1'b0};
    assign w_diff      = i_dividend - w_times_ten;

    assign o_result.quotient  = w_quot;
    assign o_result.remainder = w_diff[3:0];

endmodule

### hw/rtl/char_lcd_nibble_writer.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_writer
// Turns command, data, cursor and decimal items into 4-bit LCD nibble beats.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in) takes one item at a time.
//   Output channel (o_out_valid / i_out_ready, o_out) gives one beat per
//   enable strobe: high nibble first, with last set on the item's final beat.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the two row
//   base addresses; it is always ready and should be used while idle.
// Timing:
//   Command, data and cursor items: first beat in the cycle after acceptance,
//   two beats, ready again the cycle after the last beat is taken.
//   Decimal items: one digit per cycle through the shared divide-by-ten
//   unit (1 to 5 digits), then per digit a load state and two beats.
//   Cursor moves off the display give no beats and free the input at once.
// Reset: returns to idle with the base addresses at 0x80 and 0xC0.
// Receiver stall: the current beat holds until taken; input stays not ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_writer #(
    parameter int COLUMNS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [clnw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  clnw_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output clnw_pkg::t_out_item                 o_out
);
    import clnw_pkg::*;

    localparam logic [5:0] COL_LIMIT = 6'(COLUMNS);

    t_state             r_state, n_state;
    logic [7:0]         r_line_one, r_line_two;
    logic [7:0]         r_byte, n_byte;
    logic               r_rs, n_rs;
    logic               r_final, n_final;
    logic               r_half, n_half;
    logic [15:0]        r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [3:0]         r_digits [MAX_DIGITS];

    logic               w_in_acc, w_out_acc;
    logic               w_cursor_ok;
    logic [7:0]         w_base;
    logic [CNT_W-1:0]   w_rd_idx;
    logic               w_digit_we;
    t_div_result        w_div;

    // Shared divide-by-ten unit
    clnw_div10 u_div10 (
        .i_dividend (r_rem),
        .o_result   (w_div)
    );

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

    // Drive the current beat from the held byte
    assign o_out.nibble     = r_half ? r_byte[3:0] : r_byte[7:4];
    assign o_out.reg_select = r_rs;
    assign o_out.last       = r_half && r_final;

    assign w_cursor_ok = ({1'b0, i_in.column} < COL_LIMIT) &&
                         (i_in.row inside {ROW_FIRST, ROW_SECOND});
    assign w_base      = (i_in.row == ROW_FIRST) ? r_line_one : r_line_two;
    assign w_rd_idx    = r_cnt - CNT_W'(1);
    assign w_digit_we  = (r_state == ST_CONV) && (r_cnt < CNT_W'(MAX_DIGITS));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_one <= LINE_ONE_RESET;
            r_line_two <= LINE_TWO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_ONE_BASE: r_line_one <= i_cfg_data;
                CFG_LINE_TWO_BASE: r_line_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_half  <= 1'b0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_rs    <= n_rs;
        r_final <= n_final;
    end

    // Digit store, filled least significant first
    always_ff @(posedge i_clk) begin
        if (w_digit_we) begin
            r_digits[r_cnt] <= w_div.remainder;
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state = r_state;
        n_byte  = r_byte;
        n_rs    = r_rs;
        n_final = r_final;
        n_half  = r_half;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_half = 1'b0;
                    case (i_in.kind)
                        KIND_CMD, KIND_DATA: begin
                            n_byte  = i_in.value[7:0];
                            n_rs    = (i_in.kind == KIND_DATA) ? RS_DATA : RS_INSTR;
                            n_final = 1'b1;
                            n_state = ST_EMIT;
                        end
                        KIND_CURSOR: begin
                            n_byte  = w_base + {3'b000, i_in.column};
                            n_rs    = RS_INSTR;
                            n_final = 1'b1;
                            if (w_cursor_ok) begin
                                n_state = ST_EMIT;
                            end
                        end
                        KIND_NUMBER: begin
                            n_rem   = i_in.value;
                            n_cnt   = '0;
                            n_state = ST_CONV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONV: begin
                // One digit per cycle; stop once the quotient runs out
                if (w_digit_we) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_rem = {3'b000, w_div.quotient};
                if (w_div.quotient == '0) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Fetch the next digit, most significant first
                n_byte  = ASCII_ZERO + {4'h0, r_digits[w_rd_idx]};
                n_rs    = RS_DATA;
                n_final = (r_cnt == CNT_W'(1));
                n_cnt   = w_rd_idx;
                n_half  = 1'b0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    if (!r_half) begin
                        n_half = 1'b1;
                    end else if (r_cnt != '0) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Never take an item while a beat is on offer
    `ASSERT_IMPL(a_ready_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    // The final beat of an item frees the input next cycle
    `ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, w_out_acc && o_out.last, o_in_ready)
    // Beats of one item follow without reopening the input
    `ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, w_out_acc && !o_out.last, !o_in_ready)
    // Digit count stays within the store
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_DIGITS))

endmodule
